// ===== rtl/psms_pkg.sv =====
// ----------------------------------------------------------------------------
// psms_pkg : shared types and constants for the scan-match scorer
// Field widths, register index codes, reset values and the structs that
// pass between the transform, memory and control blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package psms_pkg;

   // request / result field widths
   localparam int MAP_ADDR_W  = 18;
   localparam int MAP_VALUE_W = 8;
   localparam int POINT_W     = 16;
   localparam int SCORE_W     = 20;

   // pose and map size register widths
   localparam int TRIG_W = 18;
   localparam int POSE_W = 26;
   localparam int SIZE_W = 10;

   // transform arithmetic: 16 x 18 products, then two products plus offset
   localparam int PROD_W = POINT_W + TRIG_W;
   localparam int SUM_W  = PROD_W + 2;

   // size limit compare width, holds any map dimension up to 4096
   localparam int LIM_W = 13;

   // largest addressable store
   localparam int ADDR_SPACE = 1 << MAP_ADDR_W;

   // saturation point of the running sum
   localparam logic [SCORE_W-1:0] SUM_MAX = {SCORE_W{1'b1}};

   // register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_COS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_POSE_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_POSE_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_HEIGHT = 3'd5;

   localparam logic signed [TRIG_W-1:0] COS_RESET  = 18'sh10000;
   localparam logic signed [TRIG_W-1:0] SIN_RESET  = '0;
   localparam logic signed [POSE_W-1:0] POSE_RESET = '0;
   localparam logic [SIZE_W-1:0]        SIZE_RESET = 10'd512;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_SCORE = 1'b1;

   // pose and map size as held by the register block
   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_q16;
      logic signed [TRIG_W-1:0] sin_q16;
      logic signed [POSE_W-1:0] pose_x_fixed;
      logic signed [POSE_W-1:0] pose_y_fixed;
      logic [SIZE_W-1:0]        cols_in_use;
      logic [SIZE_W-1:0]        rows_in_use;
   } psms_cfg_type;

   // per-stage control: wr marks a map write, hit a memory access,
   // last a score request that closes the scan
   typedef struct packed {
      logic valid;
      logic wr;
      logic hit;
      logic last;
   } psms_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/psms_if.sv =====
// ----------------------------------------------------------------------------
// psms_if : request and result channels of the scan-match scorer
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface psms_req_if;
   import psms_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [MAP_ADDR_W-1:0]         map_addr;
   logic [MAP_VALUE_W-1:0]        map_value;
   logic signed [POINT_W-1:0]     point_x;
   logic signed [POINT_W-1:0]     point_y;
   logic                          last_point;

   modport source (
      output valid, req_type, map_addr, map_value, point_x, point_y, last_point,
      input  ready
   );

   modport sink (
      input  valid, req_type, map_addr, map_value, point_x, point_y, last_point,
      output ready
   );
endinterface

interface psms_rsp_if;
   import psms_pkg::*;

   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score_sum;

   modport source (
      output valid, score_sum,
      input  ready
   );

   modport sink (
      input  valid, score_sum,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/psms_csr.sv =====
// ----------------------------------------------------------------------------
// psms_csr : pose and map size registers
// APB-style register block, zero wait states; six registers at 4-byte pitch.
// ----------------------------------------------------------------------------
`default_nettype none

module psms_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [psms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [psms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [psms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                              csr_pready,
   output      psms_pkg::psms_cfg_type            cfg
);
   import psms_pkg::*;

   psms_cfg_type          cfg_ff;
   psms_cfg_type          cfg_in;
   logic                  wr_en;
   logic [CSR_IDX_W-1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            CSR_IDX_COS:    cfg_in.cos_q16      = csr_pwdata[TRIG_W-1:0];
            CSR_IDX_SIN:    cfg_in.sin_q16      = csr_pwdata[TRIG_W-1:0];
            CSR_IDX_POSE_X: cfg_in.pose_x_fixed = csr_pwdata[POSE_W-1:0];
            CSR_IDX_POSE_Y: cfg_in.pose_y_fixed = csr_pwdata[POSE_W-1:0];
            CSR_IDX_WIDTH:  cfg_in.cols_in_use  = csr_pwdata[SIZE_W-1:0];
            CSR_IDX_HEIGHT: cfg_in.rows_in_use  = csr_pwdata[SIZE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_q16      <= COS_RESET;
         cfg_ff.sin_q16      <= SIN_RESET;
         cfg_ff.pose_x_fixed <= POSE_RESET;
         cfg_ff.pose_y_fixed <= POSE_RESET;
         cfg_ff.cols_in_use  <= SIZE_RESET;
         cfg_ff.rows_in_use  <= SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, raw register bits
   always_comb begin
      case (reg_idx)
         CSR_IDX_COS:    csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.cos_q16));
         CSR_IDX_SIN:    csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.sin_q16));
         CSR_IDX_POSE_X: csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.pose_x_fixed));
         CSR_IDX_POSE_Y: csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.pose_y_fixed));
         CSR_IDX_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.cols_in_use);
         CSR_IDX_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.rows_in_use);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/psms_xform.sv =====
// ----------------------------------------------------------------------------
// psms_xform : point transform and map address pipeline
// Three stages: rotation products, sum with offset, floor shift with bounds
// check and map index. Map writes ride the same stages to keep order.
// ----------------------------------------------------------------------------
`default_nettype none

module psms_xform #(
   parameter int MAP_MAX_WIDTH  = 512,
   parameter int MAP_MAX_HEIGHT = 512,
   parameter int FRAC_BITS      = 16,
   parameter int STORE_DEPTH    = 262144
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                adv,
   input  wire logic                                acc,
   input  wire logic                                req_type,
   input  wire logic [psms_pkg::MAP_ADDR_W-1:0]     map_addr,
   input  wire logic [psms_pkg::MAP_VALUE_W-1:0]    map_value,
   input  wire logic signed [psms_pkg::POINT_W-1:0] point_x,
   input  wire logic signed [psms_pkg::POINT_W-1:0] point_y,
   input  wire logic                                last_point,
   input  wire psms_pkg::psms_cfg_type              cfg,
   output      psms_pkg::psms_ctl_type              ctl,
   output      logic [$clog2(STORE_DEPTH)-1:0]      mem_addr,
   output      logic [psms_pkg::MAP_VALUE_W-1:0]    mem_wdata
);
   import psms_pkg::*;

   localparam int AW      = $clog2(STORE_DEPTH);
   localparam int COORD_W = SUM_W - FRAC_BITS;
   localparam int MAG_W   = COORD_W - 1;
   localparam int XW      = $clog2(MAP_MAX_WIDTH);
   localparam int YW      = $clog2(MAP_MAX_HEIGHT);
   localparam int IDX_W   = $clog2(MAP_MAX_WIDTH * MAP_MAX_HEIGHT);

   // stage 1: products
   psms_ctl_type               s1_ctl_ff, s1_ctl_in;
   logic signed [PROD_W-1:0]   s1_xc_ff, s1_xc_in;
   logic signed [PROD_W-1:0]   s1_ys_ff, s1_ys_in;
   logic signed [PROD_W-1:0]   s1_xs_ff, s1_xs_in;
   logic signed [PROD_W-1:0]   s1_yc_ff, s1_yc_in;
   logic [MAP_ADDR_W-1:0]      s1_addr_ff, s1_addr_in;
   logic [MAP_VALUE_W-1:0]     s1_value_ff, s1_value_in;

   // stage 2: sums
   psms_ctl_type               s2_ctl_ff, s2_ctl_in;
   logic signed [SUM_W-1:0]    s2_sx_ff, s2_sx_in;
   logic signed [SUM_W-1:0]    s2_sy_ff, s2_sy_in;
   logic [MAP_ADDR_W-1:0]      s2_addr_ff, s2_addr_in;
   logic [MAP_VALUE_W-1:0]     s2_value_ff, s2_value_in;

   // stage 3: memory command
   psms_ctl_type               s3_ctl_ff, s3_ctl_in;
   logic [AW-1:0]              s3_addr_ff, s3_addr_in;
   logic [MAP_VALUE_W-1:0]     s3_value_ff, s3_value_in;

   // stage 3 working signals
   logic signed [COORD_W-1:0]  nx, ny;
   logic [LIM_W-1:0]           wlim, hlim;
   logic                       in_map;
   logic                       wr_in_store;
   logic [IDX_W-1:0]           idx;

   // products of the rotation
   always_comb begin
      s1_ctl_in.valid = acc;
      s1_ctl_in.wr    = (req_type == REQ_WRITE);
      s1_ctl_in.hit   = 1'b0;
      s1_ctl_in.last  = (req_type == REQ_SCORE) & last_point;
      s1_xc_in        = point_x * cfg.cos_q16;
      s1_ys_in        = point_y * cfg.sin_q16;
      s1_xs_in        = point_x * cfg.sin_q16;
      s1_yc_in        = point_y * cfg.cos_q16;
      s1_addr_in      = map_addr;
      s1_value_in     = map_value;
   end

   // rotated point plus translation
   always_comb begin
      s2_ctl_in   = s1_ctl_ff;
      s2_sx_in    = SUM_W'(s1_xc_ff) - SUM_W'(s1_ys_ff) + SUM_W'(cfg.pose_x_fixed);
      s2_sy_in    = SUM_W'(s1_xs_ff) + SUM_W'(s1_yc_ff) + SUM_W'(cfg.pose_y_fixed);
      s2_addr_in  = s1_addr_ff;
      s2_value_in = s1_value_ff;
   end

   // floor shift, map bounds and row-major index
   always_comb begin
      nx   = s2_sx_ff[SUM_W-1:FRAC_BITS];
      ny   = s2_sy_ff[SUM_W-1:FRAC_BITS];
      wlim = ({3'b000, cfg.cols_in_use} > LIM_W'(MAP_MAX_WIDTH)) ?
             LIM_W'(MAP_MAX_WIDTH) : {3'b000, cfg.cols_in_use};
      hlim = ({3'b000, cfg.rows_in_use} > LIM_W'(MAP_MAX_HEIGHT)) ?
             LIM_W'(MAP_MAX_HEIGHT) : {3'b000, cfg.rows_in_use};
      in_map = !nx[COORD_W-1] && !ny[COORD_W-1] &&
               (nx[MAG_W-1:0] < MAG_W'(wlim)) && (ny[MAG_W-1:0] < MAG_W'(hlim));
      idx  = IDX_W'(ny[YW-1:0]) * IDX_W'(MAP_MAX_WIDTH) + IDX_W'(nx[XW-1:0]);
      wr_in_store = ({1'b0, s2_addr_ff} < (MAP_ADDR_W+1)'(STORE_DEPTH));

      s3_ctl_in     = s2_ctl_ff;
      s3_ctl_in.hit = s2_ctl_ff.wr ? wr_in_store : in_map;
      s3_addr_in    = s2_ctl_ff.wr ? s2_addr_ff[AW-1:0] : idx[AW-1:0];
      s3_value_in   = s2_value_ff;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else if (adv) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s2_ctl_in;
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_xc_ff    <= s1_xc_in;
         s1_ys_ff    <= s1_ys_in;
         s1_xs_ff    <= s1_xs_in;
         s1_yc_ff    <= s1_yc_in;
         s1_addr_ff  <= s1_addr_in;
         s1_value_ff <= s1_value_in;
         s2_sx_ff    <= s2_sx_in;
         s2_sy_ff    <= s2_sy_in;
         s2_addr_ff  <= s2_addr_in;
         s2_value_ff <= s2_value_in;
         s3_addr_ff  <= s3_addr_in;
         s3_value_ff <= s3_value_in;
      end
   end

   assign ctl       = s3_ctl_ff;
   assign mem_addr  = s3_addr_ff;
   assign mem_wdata = s3_value_ff;

endmodule

`default_nettype wire

// ===== rtl/psms_map.sv =====
// ----------------------------------------------------------------------------
// psms_map : distance-field map store
// Single synchronous memory, one write or one read a cycle, registered read
// data. A read issued the cycle after a write to the same entry sees it.
// ----------------------------------------------------------------------------
`default_nettype none

module psms_map #(
   parameter int STORE_DEPTH = 262144
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             adv,
   input  wire psms_pkg::psms_ctl_type           ctl_in,
   input  wire logic [$clog2(STORE_DEPTH)-1:0]   mem_addr,
   input  wire logic [psms_pkg::MAP_VALUE_W-1:0] mem_wdata,
   output      psms_pkg::psms_ctl_type           ctl_out,
   output      logic [psms_pkg::MAP_VALUE_W-1:0] rdata
);
   import psms_pkg::*;

   logic [MAP_VALUE_W-1:0] mem [STORE_DEPTH];
   logic [MAP_VALUE_W-1:0] rdata_ff;
   psms_ctl_type           ctl_ff;
   logic                   wr_en;
   logic                   rd_en;

   assign wr_en = adv & ctl_in.valid & ctl_in.hit & ctl_in.wr;
   assign rd_en = adv & ctl_in.valid & ctl_in.hit & ~ctl_in.wr;

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   // control travelling alongside the read
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign rdata   = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/pose_scan_match_score.sv =====
// ----------------------------------------------------------------------------
// pose_scan_match_score : likelihood-field scan-match scorer
// Transforms scan points by the programmed pose, looks them up in the stored
// distance-field map and accumulates a saturating score per scan.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-------------------------------------------
//   req_bus  | in  | valid / ready  | req_type, map_addr, map_value, point_x,
//            |     |                | point_y, last_point
//   rsp_bus  | out | valid / ready  | score_sum
//   csr_*    | in  | APB write/read | cos, sin, pose x/y, map width/height
//
// One request accepted per cycle unless stalled; a score is offered after its
// last point passes the products, sum, index, map read and result registers.
// The throughput is set by the single map port: one write or one read a cycle.
// Synchronous reset clears control, sets register defaults; map is not cleared.
// req_bus.ready drops only while a finished score waits in the result
// register and a further last point has reached the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module pose_scan_match_score #(
   parameter int MAP_MAX_WIDTH  = 512,
   parameter int MAP_MAX_HEIGHT = 512,
   parameter int FRAC_BITS      = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   psms_req_if.sink                               req_bus,
   psms_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [psms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [psms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [psms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                              csr_pready
);
   import psms_pkg::*;

   localparam int STORE_FULL  = MAP_MAX_WIDTH * MAP_MAX_HEIGHT;
   localparam int STORE_DEPTH = (STORE_FULL > ADDR_SPACE) ? ADDR_SPACE : STORE_FULL;
   localparam int AW          = $clog2(STORE_DEPTH);

   psms_cfg_type           cfg;
   psms_ctl_type           s3_ctl;
   psms_ctl_type           s4_ctl;
   logic [AW-1:0]          mem_addr;
   logic [MAP_VALUE_W-1:0] mem_wdata;
   logic [MAP_VALUE_W-1:0] rdata;

   logic                   adv;
   logic                   stall;
   logic                   acc;
   logic                   score_step;
   logic                   emit;
   logic [SCORE_W:0]       total;
   logic [SCORE_W-1:0]     sat;

   logic [SCORE_W-1:0]     sum_ff, sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]     score_ff, score_in;

   // registers
   psms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // transform pipeline
   psms_xform #(
      .MAP_MAX_WIDTH  (MAP_MAX_WIDTH),
      .MAP_MAX_HEIGHT (MAP_MAX_HEIGHT),
      .FRAC_BITS      (FRAC_BITS),
      .STORE_DEPTH    (STORE_DEPTH)
   ) u_xform (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .acc        (acc),
      .req_type   (req_bus.req_type),
      .map_addr   (req_bus.map_addr),
      .map_value  (req_bus.map_value),
      .point_x    (req_bus.point_x),
      .point_y    (req_bus.point_y),
      .last_point (req_bus.last_point),
      .cfg        (cfg),
      .ctl        (s3_ctl),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata)
   );

   // map store
   psms_map #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ctl_in    (s3_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .ctl_out   (s4_ctl),
      .rdata     (rdata)
   );

   // flow control: hold the pipe only when a new score meets a full output
   assign score_step = s4_ctl.valid & ~s4_ctl.wr;
   assign stall      = score_step & s4_ctl.last & rsp_valid_ff & ~rsp_bus.ready;
   assign adv        = ~stall;
   assign acc        = req_bus.valid & adv;
   assign emit       = adv & score_step & s4_ctl.last;

   assign req_bus.ready = adv;

   // saturating accumulate
   always_comb begin
      total = {1'b0, sum_ff} + ((s4_ctl.hit) ? (SCORE_W+1)'(rdata) : '0);
      sat   = total[SCORE_W] ? SUM_MAX : total[SCORE_W-1:0];

      sum_in       = sum_ff;
      score_in     = score_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      if (adv && score_step) begin
         if (s4_ctl.last) begin
            sum_in       = '0;
            score_in     = sat;
            rsp_valid_in = 1'b1;
         end else begin
            sum_in = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.score_sum = score_ff;

`ifndef SYNTHESIS
   // input held back only for a waiting result
   a_ready_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (rsp_valid_ff && !rsp_bus.ready))
      else $error("request stalled without a pending result");

   // a closed scan leaves the sum cleared and a result pending
   a_emit_clears_sum: assert property (@(posedge clock) disable iff (reset)
      emit |=> (sum_ff == '0 && rsp_valid_ff))
      else $error("sum not cleared or result missing after last point");

   // results only come from a last point
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("result raised without a last point");

   // a stalled accumulator keeps its sum
   a_sum_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sum_ff))
      else $error("running sum moved during a stall");
`endif

endmodule

`default_nettype wire
